>>> hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, fixed-point constants, sector codes and rounding multiply
// for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Q1.15 number format: ONE stands for 1.0
	localparam int FRAC_BITS = 15;
	localparam int CH_W      = 16;
	localparam int HUE_W     = 17;
	localparam int SEC_W     = 3;

	localparam logic [CH_W-1:0]  ONE        = CH_W'(1) << FRAC_BITS;
	localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(7680);   // 60 degrees, 7 fraction bits
	localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(46080);  // 360 degrees
	localparam int               NUM_SECT   = 6;

	// f = round(rem * ONE / 7680) = floor((rem * 2^(FRAC_BITS-9) + 7) / 15) for rem < 7680;
	// the divide by 15 is a multiply by a rounded-up reciprocal
	localparam int REM_W       = 16;
	localparam int REM_LO_W    = 13;
	localparam int NUM_SHIFT   = FRAC_BITS - 9;
	localparam int NUM_W       = REM_LO_W + NUM_SHIFT;
	localparam int RECIP_SHIFT = NUM_W + 4;
	localparam int RECIP_W     = RECIP_SHIFT - 3;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);
	localparam logic [NUM_W-1:0] NUM_BIAS = NUM_W'(7);

	typedef enum logic [SEC_W-1:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	// rounding fixed-point multiply, halves rounded up
	function automatic logic [CH_W:0] fx_mul(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [2*CH_W:0] prod;
		prod = (2*CH_W+1)'(a) * (2*CH_W+1)'(b);
		prod = prod + ((2*CH_W+1)'(1) << (FRAC_BITS - 1));
		return prod[FRAC_BITS +: CH_W+1];
	endfunction

endpackage

>>> hdl/hsv2rgb_hsv_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_hsv_if
// Valid/ready channel carrying one HSV pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
	logic                              valid;
	logic                              ready;
	logic [hsv2rgb_pkg::HUE_W-1:0]     hue;
	logic [hsv2rgb_pkg::CH_W-1:0]      saturation;
	logic [hsv2rgb_pkg::CH_W-1:0]      brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

>>> hdl/hsv2rgb_rgb_if.sv
// ----------------------------------------------------------------------------
// hsv2rgb_rgb_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv2rgb_rgb_if;
	logic                              valid;
	logic                              ready;
	logic [hsv2rgb_pkg::CH_W-1:0]      red;
	logic [hsv2rgb_pkg::CH_W-1:0]      green;
	logic [hsv2rgb_pkg::CH_W-1:0]      blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> hdl/hsv_to_rgb_convert.sv
// Converts one HSV pixel (hue in degrees with 7 fraction bits, saturation and value in
// Q1.15) to one RGB pixel in Q1.15 per transaction. The converter is a six-stage
// pipeline: it takes a new pixel every clock unless all stages are full and the output
// side is not ready, and a pixel is presented on the output from the sixth stage and
// leaves at the next clock edge at which the output side is ready. Each stage stalls
// only when it is full and the stage after it cannot take its pixel, so empty stages
// fill up while the output waits. Latency is set by the hue reciprocal multiply and the
// two rounds of rounding multiplies (s*f, then q and t against the value).
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// Pipelined HSV to RGB color conversion, fixed point.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert (
	input  logic                 clk,
	input  logic                 arst_n,
	hsv2rgb_hsv_if.sink          hsv,
	hsv2rgb_rgb_if.source        rgb
);

	localparam int CW = hsv2rgb_pkg::CH_W;

	logic adv1, adv2, adv3, adv4, adv5, adv6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1: hue wrap, saturation clamp
	logic [hsv2rgb_pkg::HUE_W-1:0] hw_s1;
	logic [CW-1:0]                 s_s1, v_s1;
	logic                          zero_s1;

	// stage 2: sector, remainder, p
	hsv2rgb_pkg::sector_t          sec_s2;
	logic                          big_s2;
	logic [hsv2rgb_pkg::NUM_W-1:0] num_s2;
	logic [CW-1:0]                 s_s2, v_s2, p_s2;
	logic                          zero_s2;

	// stage 3: raw fraction
	hsv2rgb_pkg::sector_t          sec_s3;
	logic                          big_s3;
	logic [CW-1:0]                 fraw_s3, s_s3, v_s3, p_s3;
	logic                          zero_s3;

	// stage 4: s*f and (1-f)*s
	hsv2rgb_pkg::sector_t          sec_s4;
	logic [CW-1:0]                 sf_s4, sfc_s4, v_s4, p_s4;
	logic                          zero_s4;

	// stage 5: q and t
	hsv2rgb_pkg::sector_t          sec_s5;
	logic [CW-1:0]                 q_s5, t_s5, v_s5, p_s5;
	logic                          zero_s5;

	// stage 6: output pixel
	logic [CW-1:0]                 red_s6, green_s6, blue_s6;

	// a stage takes a new pixel when it is empty or its pixel moves on
	assign adv6 = !vld_s6 || rgb.ready;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign hsv.ready = adv1;
	assign rgb.valid = vld_s6;
	assign rgb.red   = red_s6;
	assign rgb.green = green_s6;
	assign rgb.blue  = blue_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= hsv.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	// ---------------- stage 1
	always_ff @(posedge clk) begin
		if (adv1) begin
			if (hsv.hue >= hsv2rgb_pkg::HUE_FULL) begin
				hw_s1 <= hsv.hue - hsv2rgb_pkg::HUE_FULL;
			end else begin
				hw_s1 <= hsv.hue;
			end
			if (hsv.saturation >= hsv2rgb_pkg::ONE) begin
				s_s1 <= hsv2rgb_pkg::ONE;
			end else begin
				s_s1 <= hsv.saturation;
			end
			v_s1    <= hsv.brightness;
			zero_s1 <= (hsv.saturation == '0);
		end
	end

	// ---------------- stage 2
	logic [hsv2rgb_pkg::SEC_W-1:0] sec_cnt;
	logic [hsv2rgb_pkg::HUE_W-1:0] rem_full;
	logic [CW:0]                   p_full;

	always_comb begin
		sec_cnt = '0;
		// count thresholds passed; five of them cap the sector at magenta-red
		for (int k = 1; k < hsv2rgb_pkg::NUM_SECT; k++) begin
			if (hw_s1 >= hsv2rgb_pkg::HUE_W'(k) * hsv2rgb_pkg::HUE_SECTOR) begin
				sec_cnt = sec_cnt + hsv2rgb_pkg::SEC_W'(1);
			end
		end
		rem_full = hw_s1 - hsv2rgb_pkg::HUE_W'(sec_cnt) * hsv2rgb_pkg::HUE_SECTOR;
		p_full   = hsv2rgb_pkg::fx_mul(hsv2rgb_pkg::ONE - s_s1, v_s1);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			sec_s2  <= hsv2rgb_pkg::sector_t'(sec_cnt);
			big_s2  <= (rem_full >= hsv2rgb_pkg::HUE_SECTOR);
			num_s2  <= {rem_full[hsv2rgb_pkg::REM_LO_W-1:0],
				{hsv2rgb_pkg::NUM_SHIFT{1'b0}}} + hsv2rgb_pkg::NUM_BIAS;
			s_s2    <= s_s1;
			v_s2    <= v_s1;
			p_s2    <= p_full[CW-1:0];
			zero_s2 <= zero_s1;
		end
	end

	// ---------------- stage 3
	logic [hsv2rgb_pkg::NUM_W+hsv2rgb_pkg::RECIP_W-1:0] recip_prod;

	assign recip_prod = (hsv2rgb_pkg::NUM_W+hsv2rgb_pkg::RECIP_W)'(num_s2)
		* (hsv2rgb_pkg::NUM_W+hsv2rgb_pkg::RECIP_W)'(hsv2rgb_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (adv3) begin
			fraw_s3 <= recip_prod[hsv2rgb_pkg::RECIP_SHIFT +: CW];
			big_s3  <= big_s2;
			sec_s3  <= sec_s2;
			s_s3    <= s_s2;
			v_s3    <= v_s2;
			p_s3    <= p_s2;
			zero_s3 <= zero_s2;
		end
	end

	// ---------------- stage 4
	logic [CW-1:0] f_val;
	logic [CW:0]   sf_full, sfc_full;

	always_comb begin
		// remainder past one sector saturates the fraction at 1.0
		f_val    = big_s3 ? hsv2rgb_pkg::ONE : fraw_s3;
		sf_full  = hsv2rgb_pkg::fx_mul(s_s3, f_val);
		sfc_full = hsv2rgb_pkg::fx_mul(hsv2rgb_pkg::ONE - f_val, s_s3);
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			sf_s4   <= sf_full[CW-1:0];
			sfc_s4  <= sfc_full[CW-1:0];
			sec_s4  <= sec_s3;
			v_s4    <= v_s3;
			p_s4    <= p_s3;
			zero_s4 <= zero_s3;
		end
	end

	// ---------------- stage 5
	logic [CW:0] q_full, t_full;

	assign q_full = hsv2rgb_pkg::fx_mul(hsv2rgb_pkg::ONE - sf_s4, v_s4);
	assign t_full = hsv2rgb_pkg::fx_mul(hsv2rgb_pkg::ONE - sfc_s4, v_s4);

	always_ff @(posedge clk) begin
		if (adv5) begin
			q_s5    <= q_full[CW-1:0];
			t_s5    <= t_full[CW-1:0];
			sec_s5  <= sec_s4;
			v_s5    <= v_s4;
			p_s5    <= p_s4;
			zero_s5 <= zero_s4;
		end
	end

	// ---------------- stage 6
	logic [CW-1:0] r_sel, g_sel, b_sel;

	always_comb begin
		case (sec_s5)
			hsv2rgb_pkg::SEC_RY: begin r_sel = v_s5; g_sel = t_s5; b_sel = p_s5; end
			hsv2rgb_pkg::SEC_YG: begin r_sel = q_s5; g_sel = v_s5; b_sel = p_s5; end
			hsv2rgb_pkg::SEC_GC: begin r_sel = p_s5; g_sel = v_s5; b_sel = t_s5; end
			hsv2rgb_pkg::SEC_CB: begin r_sel = p_s5; g_sel = q_s5; b_sel = v_s5; end
			hsv2rgb_pkg::SEC_BM: begin r_sel = t_s5; g_sel = p_s5; b_sel = v_s5; end
			default:             begin r_sel = v_s5; g_sel = p_s5; b_sel = q_s5; end
		endcase
		// gray pixel: pass the value straight through
		if (zero_s5) begin
			r_sel = v_s5;
			g_sel = v_s5;
			b_sel = v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			red_s6   <= r_sel;
			green_s6 <= g_sel;
			blue_s6  <= b_sel;
		end
	end

	// ---------------- assertions
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.ready |=> vld_s1)
		else $error("accepted pixel did not enter the first stage");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !big_s3 |-> fraw_s3 <= hsv2rgb_pkg::ONE)
		else $error("hue fraction above 1.0");

	a_scale_products: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> sf_s4 <= hsv2rgb_pkg::ONE && sfc_s4 <= hsv2rgb_pkg::ONE)
		else $error("saturation product above 1.0");

	a_channels_below_value: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> p_s5 <= v_s5 && q_s5 <= v_s5 && t_s5 <= v_s5)
		else $error("p, q or t exceeds the value");

endmodule

>>> tb/tb_hsv_to_rgb_convert.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_convert
// Drives HSV pixels into the converter in random bursts while the RGB side
// stalls on its own pattern, including one long hold-off that backs up the
// pipeline. Every RGB pixel is compared with its directed row's expected pixel or a fixed-point prediction.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_convert;

	localparam int NUM_DIRECTED = 21;
	localparam int NUM_RANDOM   = 1300;
	localparam int LONG_HOLD    = 200;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 20;

	localparam int HW = hsv2rgb_pkg::HUE_W;
	localparam int CW = hsv2rgb_pkg::CH_W;
	localparam logic [CW-1:0] UNITY = hsv2rgb_pkg::ONE;

	typedef struct packed {
		logic [HW-1:0] hue;
		logic [CW-1:0] saturation;
		logic [CW-1:0] brightness;
	} hsv_pix_t;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} rgb_pix_t;

	typedef struct packed {
		logic [HW-1:0] hue;
		logic [CW-1:0] saturation;
		logic [CW-1:0] brightness;
		logic          typed;
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
	} dir_row_t;

	typedef struct {
		logic     typed;
		rgb_pix_t pix;
	} preset_t;

	// typed rows carry the expected pixel; the others go to the predictor
	dir_row_t hsv_vectors [NUM_DIRECTED] = '{
		'{17'd0,      16'd0,     16'd0,     1'b1, 16'd0,     16'd0,     16'd0},
		'{17'd92159,  16'd0,     UNITY,     1'b1, UNITY,     UNITY,     UNITY},
		'{17'd131071, 16'd0,     16'd65535, 1'b1, 16'd65535, 16'd65535, 16'd65535},
		'{17'd0,      UNITY,     UNITY,     1'b1, UNITY,     16'd0,     16'd0},
		'{17'd15360,  UNITY,     UNITY,     1'b1, 16'd0,     UNITY,     16'd0},
		'{17'd30720,  UNITY,     UNITY,     1'b1, 16'd0,     16'd0,     UNITY},
		'{17'd46080,  UNITY,     UNITY,     1'b1, UNITY,     16'd0,     16'd0},
		'{17'd3840,   16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd11520,  16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd19200,  16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd26880,  16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd34560,  16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd42240,  16'd16384, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd46079,  16'd65535, UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd92159,  16'd1,     UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd131071, 16'd20000, 16'd30000, 1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd7679,   UNITY,     UNITY,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd7680,   16'd40000, 16'd65535, 1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd99999,  16'd65535, 16'd65535, 1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd1,      16'd1,     16'd1,     1'b0, 16'd0,     16'd0,     16'd0},
		'{17'd65535,  16'd32767, 16'd32767, 1'b0, 16'd0,     16'd0,     16'd0}
	};

	logic clk;
	logic arst_n;

	hsv2rgb_hsv_if hsv_ch ();
	hsv2rgb_rgb_if rgb_ch ();

	hsv_to_rgb_convert DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	preset_t  preset_rgb [$];
	rgb_pix_t rgb_pending [$];
	int       pixels_in;
	int       mismatches;
	int       idle_cycles;
	int       burst_left;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// rounding Q1.15 multiply, halves up
	function automatic logic [31:0] q15_round_mul(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] prod;
		prod = 64'(a) * 64'(b) + (64'd1 << (hsv2rgb_pkg::FRAC_BITS - 1));
		return 32'(prod >> hsv2rgb_pkg::FRAC_BITS);
	endfunction

	function automatic rgb_pix_t rgb_of_hsv(input hsv_pix_t px);
		logic [HW-1:0]        h;
		logic [HW-1:0]        sec_idx;
		logic [63:0]          frac_num;
		logic [31:0]          unit, rem, f, s, v, p, q, t;
		hsv2rgb_pkg::sector_t sec;
		rgb_pix_t             res;
		unit = 32'(hsv2rgb_pkg::ONE);
		v = 32'(px.brightness);
		if (px.saturation == '0) begin
			res = {px.brightness, px.brightness, px.brightness};
			return res;
		end
		h = px.hue;
		if (h >= hsv2rgb_pkg::HUE_FULL)
			h = h - hsv2rgb_pkg::HUE_FULL;
		sec_idx = h / hsv2rgb_pkg::HUE_SECTOR;
		if (sec_idx > HW'(5))
			sec_idx = HW'(5);
		sec = hsv2rgb_pkg::sector_t'(sec_idx[hsv2rgb_pkg::SEC_W-1:0]);
		rem = 32'(h) - 32'(sec_idx) * 32'(hsv2rgb_pkg::HUE_SECTOR);
		frac_num = (64'(rem) << hsv2rgb_pkg::FRAC_BITS)
			+ 64'(hsv2rgb_pkg::HUE_SECTOR / 2);
		f = 32'(frac_num / 64'(hsv2rgb_pkg::HUE_SECTOR));
		if (f > unit)
			f = unit;
		s = (32'(px.saturation) >= unit) ? unit : 32'(px.saturation);
		p = q15_round_mul(unit - s, v);
		q = q15_round_mul(unit - q15_round_mul(s, f), v);
		t = q15_round_mul(unit - q15_round_mul(unit - f, s), v);
		case (sec)
			hsv2rgb_pkg::SEC_RY: res = {v[CW-1:0], t[CW-1:0], p[CW-1:0]};
			hsv2rgb_pkg::SEC_YG: res = {q[CW-1:0], v[CW-1:0], p[CW-1:0]};
			hsv2rgb_pkg::SEC_GC: res = {p[CW-1:0], v[CW-1:0], t[CW-1:0]};
			hsv2rgb_pkg::SEC_CB: res = {p[CW-1:0], q[CW-1:0], v[CW-1:0]};
			hsv2rgb_pkg::SEC_BM: res = {t[CW-1:0], p[CW-1:0], v[CW-1:0]};
			default: res = {v[CW-1:0], p[CW-1:0], q[CW-1:0]};
		endcase
		return res;
	endfunction

	function automatic hsv_pix_t random_hsv_pixel();
		hsv_pix_t    px;
		int unsigned pick;
		int unsigned edge_hue;
		pick = $urandom_range(0, 99);
		if (pick < 84) begin
			px.hue = HW'($urandom_range(0, 92159));
		end else if (pick < 95) begin
			// land on or next to a sector boundary
			edge_hue = $urandom_range(0, 11) * 7680;
			if (edge_hue > 0 && $urandom_range(0, 1))
				px.hue = HW'(edge_hue - $urandom_range(1, 4));
			else
				px.hue = HW'(edge_hue + $urandom_range(0, 4));
		end else begin
			px.hue = HW'($urandom);
		end
		pick = $urandom_range(0, 99);
		if (pick < 10)
			px.saturation = '0;
		else if (pick < 20)
			px.saturation = CW'($urandom_range(32768, 65535));
		else
			px.saturation = CW'($urandom_range(1, 32767));
		pick = $urandom_range(0, 99);
		if (pick < 5)
			px.brightness = UNITY;
		else if (pick < 10)
			px.brightness = CW'($urandom);
		else
			px.brightness = CW'($urandom_range(0, 32768));
		return px;
	endfunction

	task automatic send_pixel(input hsv_pix_t px, input logic typed, input rgb_pix_t rgb);
		preset_t entry;
		int      gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				hsv_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		entry.typed = typed;
		entry.pix   = rgb;
		preset_rgb.push_back(entry);
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= px.hue;
		hsv_ch.saturation <= px.saturation;
		hsv_ch.brightness <= px.brightness;
		@(posedge clk);
		while (!hsv_ch.ready)
			@(posedge clk);
	endtask

	// record accepted pixels first so a pass-through result still finds its expectation
	always @(posedge clk) begin
		preset_t  entry;
		rgb_pix_t want;
		hsv_pix_t px;
		if (hsv_ch.valid && hsv_ch.ready) begin
			px = {hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness};
			entry = preset_rgb.pop_front();
			rgb_pending.push_back(entry.typed ? entry.pix : rgb_of_hsv(px));
			pixels_in++;
		end
		if (rgb_ch.valid && rgb_ch.ready) begin
			if (rgb_pending.size() == 0) begin
				$error("unexpected RGB transaction: red %0d green %0d blue %0d",
					rgb_ch.red, rgb_ch.green, rgb_ch.blue);
				mismatches++;
			end else begin
				want = rgb_pending.pop_front();
				if (rgb_ch.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, rgb_ch.red);
					mismatches++;
				end
				if (rgb_ch.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, rgb_ch.green);
					mismatches++;
				end
				if (rgb_ch.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, rgb_ch.blue);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random phases of stalling, plus one long hold-off to back up the pipeline
	initial begin
		int mode;
		int len;
		bit held_off;
		held_off = 1'b0;
		rgb_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && pixels_in >= 400) begin
				held_off = 1'b1;
				rgb_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(1, 40);
			repeat (len) begin
				case (mode)
					0: rgb_ch.ready <= 1'b1;
					1: rgb_ch.ready <= 1'($urandom_range(0, 1));
					2: rgb_ch.ready <= ($urandom_range(0, 3) != 0);
					default: rgb_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		hsv_pix_t px;
		rgb_pix_t rgb;
		int       drain;
		clk = 1'b0;
		arst_n = 1'b0;
		hsv_ch.valid = 1'b0;
		hsv_ch.hue = '0;
		hsv_ch.saturation = '0;
		hsv_ch.brightness = '0;
		pixels_in = 0;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			px  = {hsv_vectors[i].hue, hsv_vectors[i].saturation, hsv_vectors[i].brightness};
			rgb = {hsv_vectors[i].red, hsv_vectors[i].green, hsv_vectors[i].blue};
			send_pixel(px, hsv_vectors[i].typed, rgb);
		end
		for (int i = 0; i < NUM_RANDOM; i++)
			send_pixel(random_hsv_pixel(), 1'b0, '0);
		hsv_ch.valid <= 1'b0;

		while (rgb_pending.size() != 0 || preset_rgb.size() != 0)
			@(posedge clk);
		for (drain = 0; drain < DRAIN_CYCLES; drain++)
			@(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_hsv_if.sv
hdl/hsv2rgb_rgb_if.sv
hdl/hsv_to_rgb_convert.sv
tb/tb_hsv_to_rgb_convert.sv
